/* design/pch_pkg.sv */
// posterized color histogram: shared types, codes and the posterize function
// depends on nothing; pch_queue, pch_front, pch_back and the unit import it
`timescale 1ns / 1ps
`default_nettype none
package pch_pkg;

  // command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_NEW  = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_IGNORE_BITS    = 2'd0;
  localparam logic [1:0] REG_MAX_COLORS     = 2'd1;
  localparam logic [1:0] REG_USE_IMPORTANCE = 2'd2;

  localparam logic [13:0] MAX_COLORS_RESET = 14'd8192;
  localparam logic [8:0]  BOOST_FULL       = 9'd256;
  localparam logic [8:0]  BOOST_HALF       = 9'd128;

  // work passed from the front to the back
  typedef struct packed {
    logic        cmd;
    logic [31:0] color;
    logic [8:0]  boost;
    logic        last;
    logic [15:0] bucket;
    logic [3:0]  way;
    logic        in_range;
  } pch_work_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] distinct_count;
    logic        overflowed;
    logic        image_done;
    logic        entry_valid;
    logic [31:0] entry_color;
    logic [31:0] entry_weight;
  } pch_result_t;

  typedef enum logic [1:0] {F_IDLE, F_MOD, F_PUSH} pch_fstate_t;

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_FILL, B_SCAN, B_SLOT, B_OUT} pch_bstate_t;

  // drop the low b bits and refill them from the top bits
  function automatic logic [7:0] posterize(input logic [7:0] c, input logic [2:0] b);
    logic [7:0] keep;
    logic [7:0] high;
    logic [3:0] sh;
    keep = (8'hFF >> b) << b;
    high = ~(8'hFF >> b);
    sh   = 4'd8 - {1'b0, b};
    return (c & keep) | ((c & high) >> sh);
  endfunction

endpackage
`default_nettype wire

/* design/pch_if.sv */
// posterized color histogram: channel interfaces for items, results and config
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface pch_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [7:0]  importance;
  logic        last_pixel;
  logic [9:0]  read_bucket;
  logic [2:0]  read_way;
  modport source (output valid, command, red, green, blue, alpha, importance,
                  last_pixel, read_bucket, read_way, input ready);
  modport sink (input valid, command, red, green, blue, alpha, importance,
                last_pixel, read_bucket, read_way, output ready);
endinterface

interface pch_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [13:0] distinct_count;
  logic        overflowed;
  logic        image_done;
  logic        entry_valid;
  logic [31:0] entry_color;
  logic [31:0] entry_weight;
  modport source (output valid, status, distinct_count, overflowed, image_done,
                  entry_valid, entry_color, entry_weight, input ready);
  modport sink (input valid, status, distinct_count, overflowed, image_done,
                entry_valid, entry_color, entry_weight, output ready);
endinterface

interface pch_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/pch_ram.sv */
// posterized color histogram: generic simple dual port ram, registered read
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module pch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/pch_queue.sv */
// posterized color histogram: two entry work queue between front and back
// depends on pch_pkg
`timescale 1ns / 1ps
`default_nettype none
module pch_queue
  import pch_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire pch_work_t push_data,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output pch_work_t      pop_data
);

  pch_work_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) fill <= fill + 2'd1;
      else if (do_pop && !do_push) fill <= fill - 2'd1;
    end
  end

endmodule
`default_nettype wire

/* design/pch_front.sv */
// posterized color histogram: front end, takes items, posterizes and hashes
// depends on pch_pkg and pch_if
`timescale 1ns / 1ps
`default_nettype none
module pch_front
  import pch_pkg::*;
#(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  pch_in_if.sink          in_ch,
  input  wire logic       enable,
  input  wire logic [2:0] ignore_bits,
  input  wire logic       use_importance,
  output logic            push_valid,
  input  wire logic       push_ready,
  output pch_work_t       push_data
);

  localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam int LOG_B = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
  // scaled reciprocal of the bucket count, estimate may be one low
  localparam logic [32:0] RECIP = 33'((64'd1 << (32 + LOG_B)) / 64'(BUCKETS));

  pch_fstate_t state, state_next;
  pch_work_t   work, work_next;
  logic [31:0] rem, rem_next;
  logic [4:0]  step, step_next;
  logic [64:0] prod, prod_next;
  logic [31:0] quot;
  logic [31:0] color_in;
  logic        accept;

  // posterized packed color of the incoming pixel
  always_comb begin
    if (in_ch.alpha == 8'd0) begin
      color_in = 32'd0;
    end else begin
      color_in = {posterize(in_ch.alpha, ignore_bits), posterize(in_ch.blue, ignore_bits),
                  posterize(in_ch.green, ignore_bits), posterize(in_ch.red, ignore_bits)};
    end
  end

  assign accept = in_ch.valid && in_ch.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          if (in_ch.command == CMD_ADD && !POW2) state_next = F_MOD;
          else state_next = F_PUSH;
        end
      end
      F_MOD: begin
        if (step == 5'd3) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ch.ready = (state == F_IDLE) && enable;
    push_valid  = (state == F_PUSH);
    push_data   = work;
    work_next   = work;
    rem_next    = rem;
    step_next   = step;
    prod_next   = prod;
    quot        = 32'd0;
    unique case (state)
      F_IDLE: begin
        work_next.cmd   = in_ch.command;
        work_next.color = (in_ch.command == CMD_ADD) ? color_in : 32'd0;
        work_next.boost = use_importance ? (BOOST_HALF + 9'(in_ch.importance)) : BOOST_FULL;
        work_next.last  = (in_ch.command == CMD_ADD) ? in_ch.last_pixel : 1'b0;
        if (in_ch.command == CMD_ADD) begin
          work_next.bucket   = 16'(color_in & 32'(BUCKETS - 1));
          work_next.way      = 4'd0;
          work_next.in_range = 1'b1;
        end else begin
          work_next.bucket   = 16'(in_ch.read_bucket);
          work_next.way      = 4'(in_ch.read_way);
          work_next.in_range = (32'(in_ch.read_bucket) < BUCKETS) &&
                               (32'(in_ch.read_way) < WAYS);
        end
        rem_next  = color_in;
        step_next = 5'd0;
      end
      F_MOD: begin
        // reciprocal multiply in two halves, then one correcting subtract
        unique case (step)
          5'd0: prod_next = 65'(work.color) * 65'(RECIP[16:0]);
          5'd1: prod_next = prod + ((65'(work.color) * 65'(RECIP[32:17])) << 17);
          5'd2: begin
            quot     = 32'(prod >> (32 + LOG_B));
            rem_next = work.color - 32'(quot * 32'(BUCKETS));
          end
          default: begin
            if (rem >= 32'(BUCKETS)) rem_next = rem - 32'(BUCKETS);
          end
        endcase
        step_next = step + 5'd1;
        work_next.bucket = 16'(rem_next);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state != F_PUSH) begin
      work <= work_next;
      rem  <= rem_next;
      step <= step_next;
      prod <= prod_next;
    end
  end

endmodule
`default_nettype wire

/* design/pch_back.sv */
// posterized color histogram: back end, bucket lookup, update and result register
// depends on pch_pkg, pch_if and pch_ram
`timescale 1ns / 1ps
`default_nettype none
module pch_back
  import pch_pkg::*;
#(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [13:0] max_colors,
  input  wire logic        pop_valid,
  output logic             pop_ready,
  input  wire pch_work_t   pop_data,
  output logic             clearing,
  pch_out_if.source        out_ch
);

  localparam int SLOTS = BUCKETS * WAYS;
  localparam int AW    = $clog2(SLOTS);
  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int FW    = $clog2(WAYS + 1);

  pch_bstate_t state, state_next;
  pch_work_t   cur;
  pch_result_t res, res_next;
  logic [FW-1:0] fill_q, fill_now, way, way_next;
  logic [13:0]   count, count_next;
  logic          ovf, ovf_next;
  logic [BW-1:0] clr;

  logic          fill_we;
  logic [BW-1:0] fill_waddr, fill_raddr;
  logic [FW-1:0] fill_wdata, fill_rdata;
  logic          color_we, weight_we;
  logic [AW-1:0] slot_waddr, slot_raddr;
  logic [31:0]   color_wdata, weight_wdata, color_rdata, weight_rdata;
  logic          can_insert, match, more_ways;
  logic [32:0]   sum;

  function automatic logic [AW-1:0] slot_index(input logic [15:0] bkt, input logic [31:0] w);
    return AW'(32'(bkt) * 32'(WAYS) + w);
  endfunction

  pch_ram #(.WIDTH(FW), .DEPTH(BUCKETS)) u_fill (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .raddr(fill_raddr), .rdata(fill_rdata)
  );
  pch_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_color (
    .clk(clk), .we(color_we), .waddr(slot_waddr), .wdata(color_wdata),
    .raddr(slot_raddr), .rdata(color_rdata)
  );
  pch_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_weight (
    .clk(clk), .we(weight_we), .waddr(slot_waddr), .wdata(weight_wdata),
    .raddr(slot_raddr), .rdata(weight_rdata)
  );

  // lookup conditions
  assign fill_now   = (state == B_FILL) ? fill_rdata : fill_q;
  assign can_insert = (32'(fill_now) < WAYS) && (count < max_colors);
  assign match      = (color_rdata == cur.color);
  assign more_ways  = (32'(way) + 32'd1 < 32'(fill_q));
  assign sum        = {1'b0, weight_rdata} + 33'(cur.boost);
  assign clearing   = (state == B_CLEAR);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (clr == BW'(BUCKETS - 1)) state_next = B_IDLE;
      B_IDLE:  if (pop_valid) state_next = B_FILL;
      B_FILL: begin
        if (cur.cmd == CMD_READ) begin
          if (cur.in_range && (32'(cur.way) < 32'(fill_rdata))) state_next = B_SLOT;
          else state_next = B_OUT;
        end else if (fill_rdata == '0) begin
          state_next = B_OUT;
        end else begin
          state_next = B_SCAN;
        end
      end
      B_SCAN: begin
        if (match || !more_ways) state_next = B_OUT;
      end
      B_SLOT:  state_next = B_OUT;
      B_OUT:   if (out_ch.ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // memory controls and result
  always_comb begin
    pop_ready    = (state == B_IDLE);
    fill_we      = 1'b0;
    fill_waddr   = cur.bucket[BW-1:0];
    fill_wdata   = fill_now + FW'(1);
    fill_raddr   = pop_data.bucket[BW-1:0];
    color_we     = 1'b0;
    weight_we    = 1'b0;
    slot_waddr   = slot_index(cur.bucket, 32'(fill_now));
    slot_raddr   = slot_index(cur.bucket, 32'd0);
    color_wdata  = cur.color;
    weight_wdata = 32'(cur.boost);
    res_next     = res;
    count_next   = count;
    ovf_next     = ovf;
    way_next     = way;

    // add result after a miss: insert or overflow
    if ((state == B_FILL && cur.cmd == CMD_ADD && fill_rdata == '0) ||
        (state == B_SCAN && !match && !more_ways)) begin
      if (can_insert) begin
        fill_we    = 1'b1;
        color_we   = 1'b1;
        weight_we  = 1'b1;
        count_next = count + 14'd1;
        res_next.status       = ST_NEW;
        res_next.entry_valid  = 1'b1;
        res_next.entry_weight = 32'(cur.boost);
      end else begin
        ovf_next = 1'b1;
        res_next.status       = ST_OVF;
        res_next.entry_valid  = 1'b0;
        res_next.entry_weight = 32'd0;
      end
      res_next.entry_color = cur.color;
    end

    unique case (state)
      B_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr;
        fill_wdata = '0;
      end
      B_FILL: begin
        way_next   = '0;
        slot_raddr = slot_index(cur.bucket, (cur.cmd == CMD_READ) ? 32'(cur.way) : 32'd0);
        if (cur.cmd == CMD_READ) begin
          res_next.status       = ST_READ;
          res_next.entry_valid  = 1'b0;
          res_next.entry_color  = 32'd0;
          res_next.entry_weight = 32'd0;
        end
      end
      B_SCAN: begin
        way_next   = way + FW'(1);
        slot_raddr = slot_index(cur.bucket, 32'(way) + 32'd1);
        if (match) begin
          weight_we    = 1'b1;
          slot_waddr   = slot_index(cur.bucket, 32'(way));
          weight_wdata = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          res_next.status       = ST_HIT;
          res_next.entry_valid  = 1'b1;
          res_next.entry_color  = cur.color;
          res_next.entry_weight = weight_wdata;
        end
      end
      B_SLOT: begin
        res_next.entry_valid  = 1'b1;
        res_next.entry_color  = color_rdata;
        res_next.entry_weight = weight_rdata;
      end
      default: begin
      end
    endcase

    res_next.distinct_count = count_next;
    res_next.overflowed     = ovf_next;
    res_next.image_done     = cur.last;
  end

  // result channel
  assign out_ch.valid          = (state == B_OUT);
  assign out_ch.status         = res.status;
  assign out_ch.distinct_count = res.distinct_count;
  assign out_ch.overflowed     = res.overflowed;
  assign out_ch.image_done     = res.image_done;
  assign out_ch.entry_valid    = res.entry_valid;
  assign out_ch.entry_color    = res.entry_color;
  assign out_ch.entry_weight   = res.entry_weight;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      clr   <= '0;
      count <= 14'd0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) clr <= clr + BW'(1);
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == B_IDLE) cur <= pop_data;
    if (state == B_FILL) fill_q <= fill_rdata;
    way <= way_next;
    if (state != B_OUT) res <= res_next;
  end

endmodule
`default_nettype wire

/* design/posterized_color_histogram_unit.sv */
// Posterized color histogram unit: weighted hash table of distinct RGBA colors.
// Channels: in_ch takes add and read items, out_ch returns one result per item,
// cfg writes ignore_bits (0), max_colors (1) and use_importance (2); cfg is
// always ready; the user must write cfg only while the unit is idle, which the
// unit does not enforce. A front end posterizes the pixel and hashes it to a
// bucket, taking a new item only once the last is in the queue; with BUCKETS
// not a power of two an add also passes a reciprocal multiply. A two entry
// queue feeds the back end, which reads the bucket fill, then compares one way
// per cycle from the slot memory port and writes the update. An add result
// follows the compares up to a match, a read result the fill read and, if the
// way is filled, a slot read; the back end takes a new item only once its
// result is accepted. The result sits in an output register; while the
// receiver stalls the front end still takes up to three further items, two
// queued and one held in the front end. After reset the bucket fill memory is
// cleared, one bucket per cycle, taking no item; counts and flags start at zero.
// depends on pch_pkg, pch_if, pch_front, pch_queue, pch_back
`timescale 1ns / 1ps
`default_nettype none
module posterized_color_histogram_unit
  import pch_pkg::*;
#(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pch_in_if.sink     in_ch,
  pch_out_if.source  out_ch,
  pch_cfg_if.sink    cfg
);

  logic [2:0]  ignore_bits;
  logic [13:0] max_colors;
  logic        use_importance;
  logic        clearing;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  pch_work_t   push_data, pop_data;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_bits    <= 3'd0;
      max_colors     <= MAX_COLORS_RESET;
      use_importance <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_IGNORE_BITS:    ignore_bits    <= cfg.data[2:0];
        REG_MAX_COLORS:     max_colors     <= cfg.data;
        REG_USE_IMPORTANCE: use_importance <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  pch_front #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .enable(!clearing),
    .ignore_bits(ignore_bits), .use_importance(use_importance),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  pch_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  pch_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
    .clk(clk), .rst(rst), .max_colors(max_colors),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .clearing(clearing), .out_ch(out_ch)
  );

endmodule
`default_nettype wire
